FILE: hdl/det_pkg.sv
// Shared types and constants for the due event timer table.
// Used by the top level, the entry RAM instance and the port checker.
// Depends on nothing else.
`default_nettype none

package det_pkg;

    localparam int CAPACITY = 64;
    localparam int ID_WIDTH = 16;
    localparam int TIME_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = ID_WIDTH + TIME_W;

    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

`default_nettype wire

FILE: hdl/det_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Holds the (object id, due time) entries of the timer table; no dependencies.
`default_nettype none

module det_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/due_event_timer_table_top.sv
// Top level of the due event timer table: command sequencer, shared compare unit
// and result register. Depends on det_pkg and det_ram.
//
// Usage:
//   A command is taken at a rising edge where start is high and busy is low.
//   i_cmd selects add, remove by id, pop earliest due or set current time.
//   Each command yields exactly one result, shown for a single cycle with
//   o_valid high; the receiver must take it then, as it cannot stall the block.
//   Add and set time finish without leaving idle: the result appears in the cycle
//   after the transaction and busy never rises, so a new command may follow at once.
//   Remove and pop walk the entry RAM through its single read port, one entry a
//   cycle: a scan over the N held entries, then a shift of the entries behind the
//   removed one down by one place (no entry moves when the last entry goes). Busy
//   stays high throughout, and the result appears in the same cycle as busy falls.
//   An empty table answers remove and pop without leaving idle, so busy never rises.
//   A synchronous reset empties the table, clears the current time and the dirty
//   flag, and drops any command in flight; RAM contents are not cleared.
`default_nettype none

module due_event_timer_table_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [det_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [det_pkg::ID_WIDTH-1:0]   i_object_id,
    input  wire logic [det_pkg::TIME_W-1:0]     i_time_value,
    output logic                                o_valid,
    output logic [det_pkg::STATUS_W-1:0]        o_status,
    output logic [det_pkg::ID_WIDTH-1:0]        o_popped_id,
    output logic [det_pkg::TIME_W-1:0]          o_popped_time,
    output logic                                o_dirty,
    output logic [det_pkg::CNT_W-1:0]           o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [det_pkg::CMD_W-1:0]       r_cmd, n_cmd;
    logic [det_pkg::ID_WIDTH-1:0]    r_id, n_id;
    logic [det_pkg::TIME_W-1:0]      r_cur_time, n_cur_time;
    logic                            r_dirty, n_dirty;
    logic [det_pkg::CNT_W-1:0]       r_count, n_count;
    logic [det_pkg::CNT_W-1:0]       r_ptr, n_ptr;
    logic [det_pkg::CNT_W-1:0]       r_tag, n_tag;
    logic                            r_tag_vld, n_tag_vld;
    logic                            r_hit, n_hit;
    logic [det_pkg::IDX_W-1:0]       r_pos, n_pos;
    logic [det_pkg::TIME_W-1:0]      r_best, n_best;
    logic [det_pkg::ID_WIDTH-1:0]    r_best_id, n_best_id;
    logic                            r_valid, n_valid;
    logic [det_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [det_pkg::ID_WIDTH-1:0]    r_pid, n_pid;
    logic [det_pkg::TIME_W-1:0]      r_ptime, n_ptime;

    logic                            ram_we;
    logic [det_pkg::IDX_W-1:0]       ram_waddr;
    logic [det_pkg::ENTRY_W-1:0]     ram_wdata;
    logic [det_pkg::ENTRY_W-1:0]     ram_q;
    logic [det_pkg::ID_WIDTH-1:0]    q_id;
    logic [det_pkg::TIME_W-1:0]      q_time;
    logic [det_pkg::CNT_W-1:0]       prev_tag;
    logic [det_pkg::CNT_W-1:0]       pos_next;
    logic [det_pkg::TIME_W-1:0]      cmp_a, cmp_b;
    logic                            cmp_le, cmp_lt;
    logic                            stream_done;

    det_ram #(
        .DEPTH (det_pkg::CAPACITY),
        .WIDTH (det_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[det_pkg::IDX_W-1:0]),
        .o_rdata (ram_q)
    );

    assign q_id     = ram_q[det_pkg::ENTRY_W-1 -: det_pkg::ID_WIDTH];
    assign q_time   = ram_q[det_pkg::TIME_W-1:0];
    assign prev_tag = r_tag - 1'b1;
    assign pos_next = det_pkg::CNT_W'(r_pos) + 1'b1;

    // The single time comparator serves the add check and the pop scan.
    assign cmp_a  = (r_state == S_IDLE) ? i_time_value : q_time;
    assign cmp_b  = (r_state == S_IDLE) ? r_cur_time : r_best;
    assign cmp_le = (cmp_a <= cmp_b);
    assign cmp_lt = (cmp_a < cmp_b);

    assign stream_done = (r_ptr == r_count) && !r_tag_vld;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_id       = r_id;
        n_cur_time = r_cur_time;
        n_dirty    = r_dirty;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_tag      = r_tag;
        n_tag_vld  = r_tag_vld;
        n_hit      = r_hit;
        n_pos      = r_pos;
        n_best     = r_best;
        n_best_id  = r_best_id;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_pid      = r_pid;
        n_ptime    = r_ptime;
        ram_we     = 1'b0;
        ram_waddr  = r_count[det_pkg::IDX_W-1:0];
        ram_wdata  = {i_object_id, i_time_value};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_id      = i_object_id;
                    n_pid     = '0;
                    n_ptime   = '0;
                    n_ptr     = '0;
                    n_tag_vld = 1'b0;
                    n_hit     = 1'b0;
                    n_pos     = '0;
                    n_best    = r_cur_time;
                    unique case (i_cmd)
                        det_pkg::CMD_ADD: begin
                            n_valid = 1'b1;
                            if (r_count >= det_pkg::CNT_CAP) begin
                                n_status = det_pkg::ST_FULL;
                            end else begin
                                n_status = det_pkg::ST_DONE;
                                ram_we   = 1'b1;
                                n_count  = r_count + 1'b1;
                                if (cmp_le) begin
                                    n_dirty = 1'b1;
                                end
                            end
                        end
                        det_pkg::CMD_SET: begin
                            n_valid    = 1'b1;
                            n_status   = det_pkg::ST_DONE;
                            n_cur_time = i_time_value;
                        end
                        det_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = det_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = det_pkg::ST_NONE_DUE;
                                n_dirty  = 1'b0;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ptr < r_count) begin
                    n_ptr     = r_ptr + 1'b1;
                    n_tag     = r_ptr;
                    n_tag_vld = 1'b1;
                end else begin
                    n_tag_vld = 1'b0;
                end
                if (r_tag_vld) begin
                    if (r_cmd == det_pkg::CMD_POP) begin
                        if (cmp_le && (!r_hit || cmp_lt)) begin
                            n_hit     = 1'b1;
                            n_pos     = r_tag[det_pkg::IDX_W-1:0];
                            n_best    = q_time;
                            n_best_id = q_id;
                        end
                    end else if (q_id == r_id) begin
                        n_hit = 1'b1;
                        n_pos = r_tag[det_pkg::IDX_W-1:0];
                    end
                end
                if (stream_done) begin
                    if (r_hit) begin
                        n_state = S_SHIFT;
                        n_ptr   = pos_next;
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        if (r_cmd == det_pkg::CMD_POP) begin
                            n_status = det_pkg::ST_NONE_DUE;
                            n_dirty  = 1'b0;
                        end else begin
                            n_status = det_pkg::ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_SHIFT: begin
                if (r_ptr < r_count) begin
                    n_ptr     = r_ptr + 1'b1;
                    n_tag     = r_ptr;
                    n_tag_vld = 1'b1;
                end else begin
                    n_tag_vld = 1'b0;
                end
                if (r_tag_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_tag[det_pkg::IDX_W-1:0];
                    ram_wdata = ram_q;
                end
                if (stream_done) begin
                    n_state = S_IDLE;
                    n_valid = 1'b1;
                    n_count = r_count - 1'b1;
                    if (r_cmd == det_pkg::CMD_POP) begin
                        n_status = det_pkg::ST_POPPED;
                        n_pid    = r_best_id;
                        n_ptime  = r_best;
                    end else begin
                        n_status = det_pkg::ST_DONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_time <= '0;
            r_dirty    <= 1'b0;
            r_count    <= '0;
            r_tag_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_time <= n_cur_time;
            r_dirty    <= n_dirty;
            r_count    <= n_count;
            r_tag_vld  <= n_tag_vld;
            r_hit      <= n_hit;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_id      <= n_id;
        r_ptr     <= n_ptr;
        r_tag     <= n_tag;
        r_pos     <= n_pos;
        r_best    <= n_best;
        r_best_id <= n_best_id;
        r_status  <= n_status;
        r_pid     <= n_pid;
        r_ptime   <= n_ptime;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_popped_id   = r_pid;
    assign o_popped_time = r_ptime;
    assign o_dirty       = r_dirty;
    assign o_entry_count = r_count;

endmodule

`default_nettype wire

FILE: hdl/det_checker.sv
// Port-level checker for the due event timer table, bound to the top level.
// Depends on det_pkg and on the port names of due_event_timer_table_top.
`default_nettype none

module det_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           o_valid,
    input wire logic [det_pkg::STATUS_W-1:0]   o_status,
    input wire logic [det_pkg::ID_WIDTH-1:0]   o_popped_id,
    input wire logic [det_pkg::TIME_W-1:0]     o_popped_time,
    input wire logic                           o_dirty,
    input wire logic [det_pkg::CNT_W-1:0]      o_entry_count
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("Accepted transaction produced neither busy nor a result.");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && o_valid) |-> $past(busy))
        else $error("Result shown in the first busy cycle of a transaction.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= det_pkg::CNT_CAP))
        else $error("Entry count exceeds the table capacity.");

    a_pop_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != det_pkg::ST_POPPED)) |->
            ((o_popped_id == '0) && (o_popped_time == '0)))
        else $error("Popped fields non-zero on a result that popped nothing.");

    a_none_due_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == det_pkg::ST_NONE_DUE)) |-> !o_dirty)
        else $error("Dirty flag still set after a pop found nothing due.");

endmodule

bind due_event_timer_table_top det_checker u_det_checker (.*);

`default_nettype wire

FILE: bench/tb_due_event_timer_table_top.sv
`timescale 1ns / 1ps
// Self-checking bench for due_event_timer_table_top: directed and random command streams
// are checked against an in-bench model of the entry table, current time and dirty flag.
// Depends on det_pkg and the RTL of the block.

module tb_due_event_timer_table_top;

    localparam int ITEM_TOTAL  = 1750;
    localparam int IDLE_LIMIT  = 5000;
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [det_pkg::STATUS_W-1:0] status;
        logic [det_pkg::ID_WIDTH-1:0] popped_id;
        logic [det_pkg::TIME_W-1:0]   popped_time;
        logic                         dirty;
        logic [det_pkg::CNT_W-1:0]    entry_count;
    } t_table_result;

    typedef struct packed {
        logic [det_pkg::CMD_W-1:0]    cmd;
        logic [det_pkg::ID_WIDTH-1:0] object_id;
        logic [det_pkg::TIME_W-1:0]   time_value;
        logic [4:0]                   gap;
        logic                         wait_idle;
        t_table_result                outcome;
    } t_table_cmd;

    typedef enum {MIX_FILL, MIX_EMPTY, MIX_ANY, MIX_NOISE} t_burst_mix;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         start        = 1'b0;
    logic [det_pkg::CMD_W-1:0]    i_cmd        = det_pkg::CMD_ADD;
    logic [det_pkg::ID_WIDTH-1:0] i_object_id  = '0;
    logic [det_pkg::TIME_W-1:0]   i_time_value = '0;
    logic                         busy;
    logic                         o_valid;
    logic [det_pkg::STATUS_W-1:0] o_status;
    logic [det_pkg::ID_WIDTH-1:0] o_popped_id;
    logic [det_pkg::TIME_W-1:0]   o_popped_time;
    logic                         o_dirty;
    logic [det_pkg::CNT_W-1:0]    o_entry_count;

    logic [det_pkg::ID_WIDTH-1:0] model_ids [det_pkg::CAPACITY];
    logic [det_pkg::TIME_W-1:0]   model_due [det_pkg::CAPACITY];
    int                           model_count = 0;
    logic [det_pkg::TIME_W-1:0]   model_now   = '0;
    logic                         model_dirty = 1'b0;

    t_table_cmd    cmd_backlog[$];
    t_table_result awaited_results[$];
    bit            gaps_off   = 1'b0;
    bit            drain_next = 1'b0;

    t_table_cmd    head;
    bit            head_loaded = 1'b0;
    int            head_wait   = 0;
    logic          start_next;
    t_table_result want;
    int            mismatches  = 0;
    int            idle_cycles = 0;

    due_event_timer_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_object_id   (i_object_id),
        .i_time_value  (i_time_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_popped_id   (o_popped_id),
        .o_popped_time (o_popped_time),
        .o_dirty       (o_dirty),
        .o_entry_count (o_entry_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic void drop_entry(input int pos);
        for (int k = pos; k + 1 < model_count; k++) begin
            model_ids[k] = model_ids[k + 1];
            model_due[k] = model_due[k + 1];
        end
        model_count--;
    endfunction

    function automatic t_table_result table_apply(input t_table_cmd c);
        t_table_result              r;
        logic [det_pkg::TIME_W-1:0] best;
        int                         pos;
        bit                         hit;
        r        = '0;
        r.status = det_pkg::ST_DONE;
        best     = model_now;
        pos      = 0;
        hit      = 1'b0;
        case (c.cmd)
            det_pkg::CMD_ADD: begin
                if (model_count >= det_pkg::CAPACITY) begin
                    r.status = det_pkg::ST_FULL;
                end else begin
                    model_ids[model_count] = c.object_id;
                    model_due[model_count] = c.time_value;
                    model_count++;
                    if (c.time_value <= model_now) begin
                        model_dirty = 1'b1;
                    end
                end
            end
            det_pkg::CMD_REMOVE: begin
                for (int k = model_count - 1; k >= 0 && !hit; k--) begin
                    if (model_ids[k] == c.object_id) begin
                        hit = 1'b1;
                        pos = k;
                    end
                end
                if (hit) begin
                    drop_entry(pos);
                end else begin
                    r.status = det_pkg::ST_NOT_FOUND;
                end
            end
            det_pkg::CMD_POP: begin
                for (int k = 0; k < model_count; k++) begin
                    if (model_due[k] <= best && (!hit || model_due[k] < best)) begin
                        best = model_due[k];
                        pos  = k;
                        hit  = 1'b1;
                    end
                end
                if (hit) begin
                    r.status      = det_pkg::ST_POPPED;
                    r.popped_id   = model_ids[pos];
                    r.popped_time = best;
                    drop_entry(pos);
                end else begin
                    r.status    = det_pkg::ST_NONE_DUE;
                    model_dirty = 1'b0;
                end
            end
            default: begin
                model_now = c.time_value;
            end
        endcase
        r.dirty       = model_dirty;
        r.entry_count = det_pkg::CNT_W'(model_count);
        return r;
    endfunction

    task automatic queue_cmd(input logic [det_pkg::CMD_W-1:0] cmd,
                             input logic [det_pkg::ID_WIDTH-1:0] id,
                             input logic [det_pkg::TIME_W-1:0] tv);
        t_table_cmd c;
        c            = '0;
        c.cmd        = cmd;
        c.object_id  = id;
        c.time_value = tv;
        c.gap        = gaps_off ? 5'd0 : 5'($urandom_range(0, 17));
        c.wait_idle  = drain_next;
        drain_next   = 1'b0;
        c.outcome    = table_apply(c);
        cmd_backlog.push_back(c);
    endtask

    function automatic logic [det_pkg::ID_WIDTH-1:0] pick_id();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && model_count > 0) begin
            return model_ids[$urandom_range(0, model_count - 1)];
        end
        if (sel < 8) begin
            return det_pkg::ID_WIDTH'($urandom_range(0, 7));
        end
        return det_pkg::ID_WIDTH'($urandom);
    endfunction

    function automatic logic [det_pkg::TIME_W-1:0] pick_due();
        logic [det_pkg::TIME_W:0] wide;
        int                       sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            wide = {1'b0, model_now} - $urandom_range(0, 300);
            return wide[det_pkg::TIME_W] ? '0 : wide[det_pkg::TIME_W-1:0];
        end
        if (sel < 6) begin
            wide = {1'b0, model_now} + $urandom_range(1, 300);
            return wide[det_pkg::TIME_W] ? '1 : wide[det_pkg::TIME_W-1:0];
        end
        if (sel == 6) begin
            return model_now;
        end
        if (sel == 7) begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return $urandom;
    endfunction

    function automatic logic [det_pkg::TIME_W-1:0] pick_now();
        logic [det_pkg::TIME_W:0] wide;
        int                       sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            wide = {1'b0, model_now} + $urandom_range(0, 400);
            return wide[det_pkg::TIME_W] ? '1 : wide[det_pkg::TIME_W-1:0];
        end
        if (sel < 8) begin
            return $urandom;
        end
        return (sel == 8) ? '0 : '1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            start_next = start;
            if (start && !busy) begin
                awaited_results.push_back(head.outcome);
                start_next  = 1'b0;
                head_loaded = 1'b0;
            end
            if (!head_loaded && cmd_backlog.size() != 0) begin
                head        = cmd_backlog.pop_front();
                head_wait   = head.gap;
                head_loaded = 1'b1;
            end
            if (head_loaded && !start_next &&
                !(head.wait_idle && awaited_results.size() != 0)) begin
                if (head_wait > 0) begin
                    head_wait--;
                end else begin
                    start_next = 1'b1;
                    i_cmd        <= head.cmd;
                    i_object_id  <= head.object_id;
                    i_time_value <= head.time_value;
                end
            end
            start <= start_next;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                $error("result with no transaction outstanding: status %0d", o_status);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_popped_id !== want.popped_id) begin
                    $error("popped_id: expected %0h, got %0h", want.popped_id, o_popped_id);
                    mismatches++;
                end
                if (o_popped_time !== want.popped_time) begin
                    $error("popped_time: expected %0h, got %0h",
                           want.popped_time, o_popped_time);
                    mismatches++;
                end
                if (o_dirty !== want.dirty) begin
                    $error("dirty: expected %0d, got %0d", want.dirty, o_dirty);
                    mismatches++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_entry_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_burst_mix                 mix;
        int                         span;
        int                         roll;
        bit                         mid_drained;
        logic [det_pkg::CMD_W-1:0]  pick;
        logic [det_pkg::TIME_W-1:0] tv;
        mid_drained = 1'b0;

        queue_cmd(det_pkg::CMD_POP, '0, '0);
        queue_cmd(det_pkg::CMD_REMOVE, 16'h1234, '0);
        queue_cmd(det_pkg::CMD_ADD, 16'h0000, 32'h0000_0000);
        queue_cmd(det_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(det_pkg::CMD_ADD, 16'h0005, 32'd100);
        queue_cmd(det_pkg::CMD_ADD, 16'h0005, 32'd100);
        queue_cmd(det_pkg::CMD_ADD, 16'h0007, 32'd100);
        queue_cmd(det_pkg::CMD_REMOVE, 16'h0005, '0);
        queue_cmd(det_pkg::CMD_REMOVE, 16'hABCD, '0);
        queue_cmd(det_pkg::CMD_SET, '0, 32'd50);
        queue_cmd(det_pkg::CMD_POP, '0, '0);
        queue_cmd(det_pkg::CMD_POP, '0, '0);
        queue_cmd(det_pkg::CMD_SET, '0, 32'd100);
        queue_cmd(det_pkg::CMD_POP, '0, '0);
        queue_cmd(det_pkg::CMD_POP, '0, '0);
        drain_next = 1'b1;
        queue_cmd(det_pkg::CMD_SET, '0, 32'hFFFF_FFFF);
        queue_cmd(det_pkg::CMD_ADD, 16'h8000, 32'h8000_0000);
        queue_cmd(det_pkg::CMD_POP, '0, '0);
        queue_cmd(det_pkg::CMD_POP, '0, '0);
        queue_cmd(det_pkg::CMD_POP, '0, '0);
        queue_cmd(det_pkg::CMD_SET, '0, 32'h0000_0000);

        while (cmd_backlog.size() < ITEM_TOTAL) begin
            mix      = t_burst_mix'($urandom_range(0, 3));
            span     = (mix == MIX_FILL) ? $urandom_range(70, 110) : $urandom_range(20, 60);
            gaps_off = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < span; n++) begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL: begin
                        pick = (roll < 80) ? det_pkg::CMD_ADD :
                               (roll < 90) ? det_pkg::CMD_POP : det_pkg::CMD_REMOVE;
                    end
                    MIX_EMPTY: begin
                        pick = (roll < 55) ? det_pkg::CMD_POP :
                               (roll < 80) ? det_pkg::CMD_REMOVE :
                               (roll < 92) ? det_pkg::CMD_SET : det_pkg::CMD_ADD;
                    end
                    default: begin
                        pick = det_pkg::CMD_W'($urandom_range(0, 3));
                    end
                endcase
                if (mix == MIX_NOISE) begin
                    queue_cmd(pick, det_pkg::ID_WIDTH'($urandom), $urandom);
                end else begin
                    tv = (pick == det_pkg::CMD_SET) ? pick_now() : pick_due();
                    queue_cmd(pick, pick_id(), tv);
                end
            end
            if (!mid_drained && cmd_backlog.size() > ITEM_TOTAL / 2) begin
                mid_drained = 1'b1;
                drain_next  = 1'b1;
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_backlog.size() != 0 || head_loaded) begin
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/det_pkg.sv
hdl/det_ram.sv
hdl/due_event_timer_table_top.sv
hdl/det_checker.sv
bench/tb_due_event_timer_table_top.sv
